>>> hw/rtl/vnos_pkg.sv
// ----------------------------------------------------------------------------
// vnos_pkg
// Shared widths, command codes and lattice offset tables for the value
// noise octave sum block.
// ----------------------------------------------------------------------------
package vnos_pkg;

   localparam int COORD_W = 20;   // Q12.8 coordinate
   localparam int FRAC_W  = 16;   // Q0.16 lattice fraction
   localparam int QUOT_W  = COORD_W + FRAC_W;
   localparam int HASH_W  = 32;   // lattice hash and Q1.30 noise
   localparam int SMP_W   = 36;   // smoothed sample, signed Q5.30
   localparam int CUB_W   = 44;   // cubic interpolation values
   localparam int NOISE_W = 40;   // output sum, Q24.16
   localparam int PERS_W  = 16;
   localparam int OCTR_W  = 4;
   localparam int SAMPLES = 7;
   localparam int NBRS    = 9;

   // output saturation limits
   localparam logic signed [NOISE_W+1:0] OUT_MAX = 42'sd549755813887;
   localparam logic signed [NOISE_W+1:0] OUT_MIN = -42'sd549755813888;

   // register map (word index)
   localparam logic REG_PERSISTENCE = 1'b0;
   localparam logic REG_OCTAVES     = 1'b1;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,      // capture coordinates, clear sum, first octave
      OP_DIV,       // start lattice split
      OP_HASH,      // start the 63 lattice hashes
      OP_SETUP_X,   // cubic coefficients, fraction X
      OP_SETUP_Y,   // cubic coefficients, fraction Y
      OP_MUL,       // product = acc * fraction
      OP_ADD_Q,
      OP_ADD_R,
      OP_END_X,     // finish an X run, shift the sample window
      OP_END_Y,     // finish the Y run
      OP_LOAD_Y,    // X results become the Y window
      OP_MUL_HI,    // high half times amplitude
      OP_MUL_LO,    // low half times amplitude
      OP_ACCUM,     // add octave term, next octave
      OP_OUTPUT     // move sum into the result register
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic hash_busy;
      logic octave_more;
   } dp_stat_type;

   // sample point offsets around the lattice point
   function automatic logic signed [1:0] sample_dx(input logic [2:0] k);
      case (k)
         3'd0, 3'd1:       sample_dx = -2'sd1;
         3'd4, 3'd6:       sample_dx = 2'sd1;
         default:          sample_dx = 2'sd0;
      endcase
   endfunction

   function automatic logic signed [1:0] sample_dy(input logic [2:0] k);
      case (k)
         3'd0, 3'd2:       sample_dy = -2'sd1;
         3'd5, 3'd6:       sample_dy = 2'sd1;
         default:          sample_dy = 2'sd0;
      endcase
   endfunction

   // 3x3 neighbors: four corners, four sides, then the center
   function automatic logic signed [1:0] nbr_dx(input logic [3:0] j);
      case (j)
         4'd0, 4'd2, 4'd4: nbr_dx = -2'sd1;
         4'd1, 4'd3, 4'd5: nbr_dx = 2'sd1;
         default:          nbr_dx = 2'sd0;
      endcase
   endfunction

   function automatic logic signed [1:0] nbr_dy(input logic [3:0] j);
      case (j)
         4'd0, 4'd1, 4'd6: nbr_dy = -2'sd1;
         4'd2, 4'd3, 4'd7: nbr_dy = 2'sd1;
         default:          nbr_dy = 2'sd0;
      endcase
   endfunction

endpackage

>>> hw/rtl/vnos_div.sv
// ----------------------------------------------------------------------------
// vnos_div
// Restoring divider, one quotient bit per cycle: (coord << 16) / divisor.
// Upper quotient bits are the lattice point, lower 16 the fraction.
// ----------------------------------------------------------------------------
module vnos_div #(
   parameter int DVW = 13
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [vnos_pkg::COORD_W-1:0] coord,
   input  logic [DVW-1:0]               divisor,
   output logic                         busy,
   output logic [vnos_pkg::QUOT_W-1:0]  quot
);

   localparam int QW    = vnos_pkg::QUOT_W;
   localparam int CNT_W = $clog2(QW + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [QW-1:0]    dq_ff, dq_in;
   logic [DVW-1:0]   rem_ff, rem_in;
   logic [DVW:0]     trial;
   logic [DVW:0]     diff;
   logic             ge;

   // one restoring step
   always_comb begin
      trial   = {rem_ff, dq_ff[QW-1]};
      diff    = trial - {1'b0, divisor};
      ge      = (trial >= {1'b0, divisor});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QW);
         dq_in   = {coord, {vnos_pkg::FRAC_W{1'b0}}};
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVW-1:0] : trial[DVW-1:0];
         dq_in  = {dq_ff[QW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign quot = dq_ff;

endmodule

>>> hw/rtl/vnos_hash.sv
// ----------------------------------------------------------------------------
// vnos_hash
// Four-stage pipelined lattice hash, one point per cycle, result as
// signed Q1.30 noise. All arithmetic wraps at 32 bits.
// ----------------------------------------------------------------------------
module vnos_hash (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [vnos_pkg::HASH_W-1:0]        a,
   input  logic [vnos_pkg::HASH_W-1:0]        b,
   output logic                               out_valid,
   output logic signed [vnos_pkg::HASH_W-1:0] noise
);

   localparam int HW = vnos_pkg::HASH_W;

   logic [3:0]    vld_ff;
   logic [HW-1:0] n0_ff, n1_ff, n2_ff;
   logic [HW-1:0] sq_ff, m_ff, h_ff;
   logic [HW-1:0] mix;

   // seed mix
   always_comb begin
      mix = a + b * 32'd57;
      mix = (mix << 13) ^ mix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
      n0_ff <= mix;
      sq_ff <= n0_ff * n0_ff;
      n1_ff <= n0_ff;
      m_ff  <= sq_ff * 32'd15731 + 32'd789221;
      n2_ff <= n1_ff;
      h_ff  <= m_ff * n2_ff + 32'd1376312589;
   end

   assign out_valid = vld_ff[3];
   assign noise     = 32'sh4000_0000 - $signed({1'b0, h_ff[HW-2:0]});

endmodule

>>> hw/rtl/vnos_datapath.sv
// ----------------------------------------------------------------------------
// vnos_datapath
// Lattice split, hash sequencing, smoothing, cubic interpolation with a
// shared multiplier, octave weighting and the saturating sum.
// ----------------------------------------------------------------------------
module vnos_datapath #(
   parameter int MAX_OCTAVES     = 8,
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vnos_pkg::dp_cmd_type                 cmd,
   output vnos_pkg::dp_stat_type                stat,
   input  logic [vnos_pkg::COORD_W-1:0]         x_coord,
   input  logic [vnos_pkg::COORD_W-1:0]         y_coord,
   input  logic [vnos_pkg::PERS_W-1:0]          persistence,
   input  logic [$clog2(MAX_OCTAVES+1)-1:0]     octave_count,
   output logic [vnos_pkg::NOISE_W-1:0]         noise_value
);

   localparam int OW   = $clog2(MAX_OCTAVES + 1);
   localparam int DVW  = OW + 1 + COORD_FRAC_BITS;
   localparam int AMPW = vnos_pkg::PERS_W + OW;
   localparam int BW   = (AMPW + 1 > vnos_pkg::FRAC_W + 1) ? AMPW + 1 : vnos_pkg::FRAC_W + 1;
   localparam int CW   = vnos_pkg::CUB_W;
   localparam int PW   = CW + BW;
   localparam int SW   = vnos_pkg::SMP_W;
   localparam int HW   = vnos_pkg::HASH_W;
   localparam int XW   = vnos_pkg::NOISE_W + 2;
   localparam int CRW  = vnos_pkg::COORD_W;
   localparam int FW   = vnos_pkg::FRAC_W;

   vnos_pkg::dp_op_type op;

   logic [CRW-1:0]        x_ff, y_ff;
   logic [OW-1:0]         t_ff;
   logic [AMPW-1:0]       amp_ff;
   logic signed [XW-3:0]  sum_ff;
   logic [XW-3:0]         out_ff;
   logic [DVW-1:0]        divisor;
   logic                  xdiv_busy, ydiv_busy;
   logic [vnos_pkg::QUOT_W-1:0] qx, qy;

   assign op = cmd.op;

   // ---- lattice split ------------------------------------------------------
   assign divisor = DVW'({t_ff, 1'b0}) << COORD_FRAC_BITS;

   vnos_div #(.DVW(DVW)) u_xdiv (
      .clock  (clock),
      .reset  (reset),
      .start  (op == vnos_pkg::OP_DIV),
      .coord  (x_ff),
      .divisor(divisor),
      .busy   (xdiv_busy),
      .quot   (qx)
   );

   vnos_div #(.DVW(DVW)) u_ydiv (
      .clock  (clock),
      .reset  (reset),
      .start  (op == vnos_pkg::OP_DIV),
      .coord  (y_ff),
      .divisor(divisor),
      .busy   (ydiv_busy),
      .quot   (qy)
   );

   // ---- hash issue ---------------------------------------------------------
   logic       iss_ff, iss_in;
   logic [2:0] ik_ff, ik_in;
   logic [3:0] ij_ff, ij_in;
   logic signed [1:0] sdx, sdy, ndx, ndy;
   logic [2:0] offx, offy;
   logic [HW-1:0] ha, hb;
   logic       h_vld;
   logic signed [HW-1:0] h_noise;

   always_comb begin
      sdx  = vnos_pkg::sample_dx(ik_ff);
      sdy  = vnos_pkg::sample_dy(ik_ff);
      ndx  = vnos_pkg::nbr_dx(ij_ff);
      ndy  = vnos_pkg::nbr_dy(ij_ff);
      offx = {sdx[1], sdx} + {ndx[1], ndx};
      offy = {sdy[1], sdy} + {ndy[1], ndy};
      ha = HW'(qx[vnos_pkg::QUOT_W-1:FW]) + {{(HW-3){offx[2]}}, offx};
      hb = HW'(qy[vnos_pkg::QUOT_W-1:FW]) + {{(HW-3){offy[2]}}, offy};
      iss_in = iss_ff;
      ik_in  = ik_ff;
      ij_in  = ij_ff;
      if (op == vnos_pkg::OP_HASH) begin
         iss_in = 1'b1;
         ik_in  = '0;
         ij_in  = '0;
      end else if (iss_ff) begin
         if (ij_ff == 4'(vnos_pkg::NBRS - 1)) begin
            ij_in = '0;
            ik_in = ik_ff + 1'b1;
            if (ik_ff == 3'(vnos_pkg::SAMPLES - 1)) begin
               iss_in = 1'b0;
            end
         end else begin
            ij_in = ij_ff + 1'b1;
         end
      end
   end

   vnos_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .in_valid (iss_ff),
      .a        (ha),
      .b        (hb),
      .out_valid(h_vld),
      .noise    (h_noise)
   );

   // ---- smoothing ----------------------------------------------------------
   logic       hrun_ff, hrun_in;
   logic [2:0] rk_ff, rk_in;
   logic [3:0] rj_ff, rj_in;
   logic signed [SW-1:0] corner_ff, corner_in, side_ff, side_in;
   logic signed [SW-1:0] hext, smooth;
   logic       v_we;

   always_comb begin
      hext      = SW'(h_noise);
      smooth    = (corner_ff >>> 2) + (side_ff >>> 1) + hext;
      hrun_in   = hrun_ff;
      rk_in     = rk_ff;
      rj_in     = rj_ff;
      corner_in = corner_ff;
      side_in   = side_ff;
      v_we      = 1'b0;
      if (op == vnos_pkg::OP_HASH) begin
         hrun_in   = 1'b1;
         rk_in     = '0;
         rj_in     = '0;
         corner_in = '0;
         side_in   = '0;
      end else if (h_vld) begin
         if (rj_ff < 4'd4) begin
            corner_in = corner_ff + hext;
            rj_in     = rj_ff + 1'b1;
         end else if (rj_ff < 4'(vnos_pkg::NBRS - 1)) begin
            side_in = side_ff + hext;
            rj_in   = rj_ff + 1'b1;
         end else begin
            v_we      = 1'b1;
            corner_in = '0;
            side_in   = '0;
            rj_in     = '0;
            rk_in     = rk_ff + 1'b1;
            if (rk_ff == 3'(vnos_pkg::SAMPLES - 1)) begin
               hrun_in = 1'b0;
            end
         end
      end
   end

   // ---- cubic interpolation and weighting ----------------------------------
   logic signed [CW-1:0] v_ff [vnos_pkg::SAMPLES];
   logic signed [CW-1:0] i_ff [4];
   logic signed [CW-1:0] p_ff, q_ff, r_ff, acc_ff;
   logic signed [CW-1:0] p_c, q_c;
   logic [FW-1:0]        f_ff;
   logic signed [CW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [PW-1:0] prod_ff, whi_ff;
   logic signed [CW-1:0] prod_sh;
   logic signed [PW-1:0] wsum;
   logic signed [XW-1:0] term, sum_ext;
   logic signed [XW-3:0] sum_sat;

   always_comb begin
      p_c = (v_ff[3] - v_ff[2]) - (v_ff[0] - v_ff[1]);
      q_c = (v_ff[0] - v_ff[1]) - p_c;
      prod_sh = $signed(prod_ff[16+CW-1:16]);
      // multiplier operand select
      case (op)
         vnos_pkg::OP_MUL_HI: mul_a = acc_ff >>> 16;
         vnos_pkg::OP_MUL_LO: mul_a = $signed({{(CW-16){1'b0}}, acc_ff[15:0]});
         default:             mul_a = acc_ff;
      endcase
      if (op == vnos_pkg::OP_MUL) begin
         mul_b = $signed({{(BW-FW){1'b0}}, f_ff});
      end else begin
         mul_b = $signed({{(BW-AMPW){1'b0}}, amp_ff});
      end
      // octave term and saturating sum
      wsum    = whi_ff + (prod_ff >>> 16);
      term    = $signed(wsum[14+XW-1:14]);
      sum_ext = XW'(sum_ff) + term;
      if (sum_ext > vnos_pkg::OUT_MAX) begin
         sum_sat = (XW-2)'(vnos_pkg::OUT_MAX);
      end else if (sum_ext < vnos_pkg::OUT_MIN) begin
         sum_sat = (XW-2)'(vnos_pkg::OUT_MIN);
      end else begin
         sum_sat = sum_ext[XW-3:0];
      end
   end

   // control registers of the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff  <= 1'b0;
         hrun_ff <= 1'b0;
         ik_ff   <= '0;
         ij_ff   <= '0;
         rk_ff   <= '0;
         rj_ff   <= '0;
         t_ff    <= '0;
      end else begin
         iss_ff  <= iss_in;
         hrun_ff <= hrun_in;
         ik_ff   <= ik_in;
         ij_ff   <= ij_in;
         rk_ff   <= rk_in;
         rj_ff   <= rj_in;
         if (op == vnos_pkg::OP_LOAD) begin
            t_ff <= OW'(1);
         end else if (op == vnos_pkg::OP_ACCUM) begin
            t_ff <= t_ff + 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      corner_ff <= corner_in;
      side_ff   <= side_in;
      if (v_we) begin
         v_ff[rk_ff] <= CW'(smooth);
      end
      case (op)
         vnos_pkg::OP_LOAD: begin
            x_ff   <= x_coord;
            y_ff   <= y_coord;
            amp_ff <= AMPW'(persistence);
            sum_ff <= '0;
         end
         vnos_pkg::OP_SETUP_X, vnos_pkg::OP_SETUP_Y: begin
            p_ff   <= p_c;
            q_ff   <= q_c;
            r_ff   <= v_ff[2] - v_ff[0];
            acc_ff <= p_c;
            f_ff   <= (op == vnos_pkg::OP_SETUP_X) ? qx[FW-1:0] : qy[FW-1:0];
         end
         vnos_pkg::OP_MUL, vnos_pkg::OP_MUL_HI: begin
            prod_ff <= PW'(mul_a) * PW'(mul_b);
         end
         vnos_pkg::OP_MUL_LO: begin
            whi_ff  <= prod_ff;
            prod_ff <= PW'(mul_a) * PW'(mul_b);
         end
         vnos_pkg::OP_ADD_Q: acc_ff <= prod_sh + q_ff;
         vnos_pkg::OP_ADD_R: acc_ff <= prod_sh + r_ff;
         vnos_pkg::OP_END_X: begin
            for (int s = 0; s < vnos_pkg::SAMPLES - 1; s++) begin
               v_ff[s] <= v_ff[s+1];
            end
            for (int s = 0; s < 3; s++) begin
               i_ff[s] <= i_ff[s+1];
            end
            i_ff[3] <= prod_sh + v_ff[1];
         end
         vnos_pkg::OP_END_Y: acc_ff <= prod_sh + v_ff[1];
         vnos_pkg::OP_LOAD_Y: begin
            for (int s = 0; s < 4; s++) begin
               v_ff[s] <= i_ff[s];
            end
         end
         vnos_pkg::OP_ACCUM: begin
            sum_ff <= sum_sat;
            amp_ff <= amp_ff + AMPW'(persistence);
         end
         vnos_pkg::OP_OUTPUT: out_ff <= sum_ff;
         default: begin
         end
      endcase
   end

   assign stat.div_busy    = xdiv_busy | ydiv_busy;
   assign stat.hash_busy   = hrun_ff;
   assign stat.octave_more = (t_ff < octave_count);
   assign noise_value      = out_ff;

endmodule

>>> hw/rtl/vnos_ctrl.sv
// ----------------------------------------------------------------------------
// vnos_ctrl
// Sequencer: octave loop, lattice split, hashing, five cubic runs,
// weighting, and the result handshake.
// ----------------------------------------------------------------------------
module vnos_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output vnos_pkg::dp_cmd_type  cmd,
   input  vnos_pkg::dp_stat_type stat
);

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_DIV, S_DIV_WAIT, S_HASH, S_HASH_WAIT,
      S_SETUP, S_MUL1, S_ADDQ, S_MUL2, S_ADDR, S_MUL3, S_END,
      S_LOADY, S_MULHI, S_MULLO, S_ACCUM, S_FINISH
   } state_type;

   state_type  state_ff;
   logic [1:0] run_ff;
   logic       yrun_ff;
   logic       valid_ff;

   // command decode
   always_comb begin
      cmd.op = vnos_pkg::OP_IDLE;
      case (state_ff)
         S_IDLE:   if (req_tvalid) cmd.op = vnos_pkg::OP_LOAD;
         S_DIV:    cmd.op = vnos_pkg::OP_DIV;
         S_HASH:   cmd.op = vnos_pkg::OP_HASH;
         S_SETUP:  cmd.op = yrun_ff ? vnos_pkg::OP_SETUP_Y : vnos_pkg::OP_SETUP_X;
         S_MUL1, S_MUL2, S_MUL3: cmd.op = vnos_pkg::OP_MUL;
         S_ADDQ:   cmd.op = vnos_pkg::OP_ADD_Q;
         S_ADDR:   cmd.op = vnos_pkg::OP_ADD_R;
         S_END:    cmd.op = yrun_ff ? vnos_pkg::OP_END_Y : vnos_pkg::OP_END_X;
         S_LOADY:  cmd.op = vnos_pkg::OP_LOAD_Y;
         S_MULHI:  cmd.op = vnos_pkg::OP_MUL_HI;
         S_MULLO:  cmd.op = vnos_pkg::OP_MUL_LO;
         S_ACCUM:  cmd.op = vnos_pkg::OP_ACCUM;
         S_FINISH: if (!valid_ff || rsp_tready) cmd.op = vnos_pkg::OP_OUTPUT;
         default:  cmd.op = vnos_pkg::OP_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         run_ff   <= '0;
         yrun_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         // result flag: set when a new result is loaded, cleared when taken
         if (state_ff == S_FINISH && (!valid_ff || rsp_tready)) begin
            valid_ff <= 1'b1;
         end else if (valid_ff && rsp_tready) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE:      if (req_tvalid) state_ff <= S_CHECK;
            S_CHECK:     state_ff <= stat.octave_more ? S_DIV : S_FINISH;
            S_DIV:       state_ff <= S_DIV_WAIT;
            S_DIV_WAIT:  if (!stat.div_busy) state_ff <= S_HASH;
            S_HASH:      state_ff <= S_HASH_WAIT;
            S_HASH_WAIT: begin
               if (!stat.hash_busy) begin
                  run_ff   <= '0;
                  yrun_ff  <= 1'b0;
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP:     state_ff <= S_MUL1;
            S_MUL1:      state_ff <= S_ADDQ;
            S_ADDQ:      state_ff <= S_MUL2;
            S_MUL2:      state_ff <= S_ADDR;
            S_ADDR:      state_ff <= S_MUL3;
            S_MUL3:      state_ff <= S_END;
            S_END: begin
               if (yrun_ff) begin
                  state_ff <= S_MULHI;
               end else if (run_ff == 2'd3) begin
                  state_ff <= S_LOADY;
               end else begin
                  run_ff   <= run_ff + 1'b1;
                  state_ff <= S_SETUP;
               end
            end
            S_LOADY: begin
               yrun_ff  <= 1'b1;
               state_ff <= S_SETUP;
            end
            S_MULHI:     state_ff <= S_MULLO;
            S_MULLO:     state_ff <= S_ACCUM;
            S_ACCUM:     state_ff <= S_CHECK;
            S_FINISH: begin
               if (!valid_ff || rsp_tready) begin
                  state_ff <= S_IDLE;
               end
            end
            default:     state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

endmodule

>>> hw/rtl/value_noise_octave_sum.sv
// ----------------------------------------------------------------------------
// value_noise_octave_sum
// Summed 2D hash value noise over octaves 1 .. count-1.
// One request in work at a time: a new one is taken only after the last has
// moved its sum into the result register. Per octave: bit-serial lattice
// split, 63 hash issues plus pipeline drain, cubic runs, check and weighting.
// A finished result waits in its own register while the next request starts.
// Reset (synchronous): idle, no result pending, CSRs at their defaults.
// ----------------------------------------------------------------------------
module value_noise_octave_sum #(
   parameter int MAX_OCTAVES     = 8,
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,    // [19:0] x_coord, [39:20] y_coord
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [39:0] noise_value
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int OW = $clog2(MAX_OCTAVES + 1);

   logic [vnos_pkg::PERS_W-1:0] persistence_ff;
   logic [vnos_pkg::OCTR_W-1:0] octave_count_ff;
   logic [OW-1:0]               count;
   vnos_pkg::dp_cmd_type        cmd;
   vnos_pkg::dp_stat_type       stat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         persistence_ff  <= 16'd8192;
         octave_count_ff <= 4'd4;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            vnos_pkg::REG_PERSISTENCE: persistence_ff  <= csr_pwdata[15:0];
            vnos_pkg::REG_OCTAVES:     octave_count_ff <= csr_pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == vnos_pkg::REG_OCTAVES) ?
                       32'(octave_count_ff) : 32'(persistence_ff);

   // octave count limited to the build maximum
   assign count = (32'(octave_count_ff) > MAX_OCTAVES) ? OW'(MAX_OCTAVES)
                                                        : OW'(octave_count_ff);

   vnos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd),
      .stat      (stat)
   );

   vnos_datapath #(
      .MAX_OCTAVES    (MAX_OCTAVES),
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .x_coord     (req_tdata[19:0]),
      .y_coord     (req_tdata[39:20]),
      .persistence (persistence_ff),
      .octave_count(count),
      .noise_value (rsp_tdata)
   );

endmodule

>>> hw/rtl/vnos_checker.sv
// ----------------------------------------------------------------------------
// vnos_checker
// Port-level checks of the request and result handshakes.
// ----------------------------------------------------------------------------
module vnos_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // out of reset: idle and nothing pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("block not idle after reset");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while busy");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

bind value_noise_octave_sum vnos_checker u_vnos_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for value_noise_octave_sum. Coordinate requests go in on the
// stream input. Each accepted request is scored against a local model of the
// octave sum, computed with the register settings in force at the time.
// Results are checked in order. Both stream sides idle in random bursts,
// and one long output stall fills the block up.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int MAX_OCT   = 8;
   localparam int FRAC_BITS = 8;
   localparam int WD_LIMIT  = 40000;
   localparam int HOLD_LEN  = 5000;
   localparam logic [2:0] ADDR_PERS = 3'd0;
   localparam logic [2:0] ADDR_OCT  = 3'd4;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // [19:0] x_coord, [39:20] y_coord
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [39:0] noise_value
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // model copy of the registers
   logic [15:0] cur_pers;
   logic [3:0]  cur_octaves;

   logic [39:0] noise_queue[$];
   int          mismatches;
   bit          quiet;
   bit          hold_req;
   int          stall_cnt;
   int          hold_cnt;
   int          idle_cycles;

   value_noise_octave_sum #(
      .MAX_OCTAVES(MAX_OCT),
      .COORD_FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- model
   function automatic longint noise_hash(bit [31:0] a, bit [31:0] b);
      bit [31:0] n;
      bit [31:0] h;
      n = a + b * 32'd57;
      n = (n << 13) ^ n;
      h = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7FFF_FFFF;
      return (longint'(1) <<< 30) - longint'({32'd0, h});
   endfunction

   function automatic longint smoothed(bit [31:0] a, bit [31:0] b);
      longint corners;
      longint sides;
      corners = noise_hash(a - 1, b - 1) + noise_hash(a + 1, b - 1)
              + noise_hash(a - 1, b + 1) + noise_hash(a + 1, b + 1);
      sides = noise_hash(a - 1, b) + noise_hash(a + 1, b)
            + noise_hash(a, b - 1) + noise_hash(a, b + 1);
      return (corners >>> 2) + (sides >>> 1) + noise_hash(a, b);
   endfunction

   function automatic longint cubic(longint v0, longint v1, longint v2, longint v3,
                                    longint f);
      longint p;
      longint q;
      longint acc;
      p   = (v3 - v2) - (v0 - v1);
      q   = (v0 - v1) - p;
      acc = ((p * f) >>> 16) + q;
      acc = ((acc * f) >>> 16) + (v2 - v0);
      return ((acc * f) >>> 16) + v1;
   endfunction

   function automatic longint octave_term(bit [19:0] xc, bit [19:0] yc, int t);
      bit [31:0] d;
      bit [31:0] ix;
      bit [31:0] iy;
      longint    fx;
      longint    fy;
      longint    v[7];
      longint    r;
      longint    amp;
      d  = (2 * t) << FRAC_BITS;
      ix = xc / d;
      iy = yc / d;
      fx = (longint'(xc % d) << 16) / d;
      fy = (longint'(yc % d) << 16) / d;
      v[0] = smoothed(ix - 1, iy - 1);
      v[1] = smoothed(ix - 1, iy);
      v[2] = smoothed(ix, iy - 1);
      v[3] = smoothed(ix, iy);
      v[4] = smoothed(ix + 1, iy);
      v[5] = smoothed(ix, iy + 1);
      v[6] = smoothed(ix + 1, iy + 1);
      r = cubic(cubic(v[0], v[1], v[2], v[3], fx), cubic(v[1], v[2], v[3], v[4], fx),
                cubic(v[2], v[3], v[4], v[5], fx), cubic(v[3], v[4], v[5], v[6], fx),
                fy);
      amp = longint'(cur_pers) * t;
      return (((r >>> 16) * amp) + (((r & 64'sh0000_0000_0000_FFFF) * amp) >>> 16)) >>> 14;
   endfunction

   function automatic logic [39:0] predict_noise(bit [19:0] xc, bit [19:0] yc);
      int     count;
      longint sum;
      count = (cur_octaves > MAX_OCT) ? MAX_OCT : cur_octaves;
      sum   = 0;
      for (int t = 1; t + 1 <= count; t++) begin
         sum += octave_term(xc, yc, t);
         if (sum > 64'sd549755813887) sum = 64'sd549755813887;
         if (sum < -64'sd549755813888) sum = -64'sd549755813888;
      end
      return sum[39:0];
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic send_coord(bit [19:0] xc, bit [19:0] yc);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {yc, xc};
      do @(posedge clock); while (!req_tready);
      noise_queue.insert(noise_queue.size(), predict_noise(xc, yc));
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_idle();
      end_burst();
      while (noise_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_PERS) cur_pers = value[15:0];
      else if (addr == ADDR_OCT) cur_octaves = value[3:0];
   endtask

   task automatic set_config(logic [15:0] pers, logic [3:0] octs);
      wait_idle();
      csr_write(ADDR_PERS, {16'd0, pers});
      csr_write(ADDR_OCT, {28'd0, octs});
   endtask

   // ---------------------------------------------------------------- output side
   always @(posedge clock) begin
      if (hold_req && hold_cnt == 0) begin
         hold_cnt = HOLD_LEN;
         hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 1'b0;
      end else if (stall_cnt > 0 && !quiet) begin
         stall_cnt--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 6) == 0) stall_cnt = $urandom_range(1, 10);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (noise_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            if (rsp_tdata !== noise_queue[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("noise_value mismatch: expected %h actual %h",
                           noise_queue[0], rsp_tdata);
            end
            void'(noise_queue.pop_front());
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_defaults();
      send_coord(20'd0, 20'd0);          // neighbors at lattice -1
      send_coord(20'hFFFFF, 20'hFFFFF);
      send_coord(20'd0, 20'hFFFFF);
      send_coord(20'hFFFFF, 20'd0);
      send_coord(20'd255, 20'd256);
      send_coord(20'h55555, 20'hAAAAA);
   endtask

   task automatic test_few_octaves();
      set_config(16'd8192, 4'd0);
      send_coord(20'h12345, 20'h6789A);
      send_coord(20'hFFFFF, 20'd0);
      set_config(16'hFFFF, 4'd1);
      send_coord(20'd0, 20'd0);
      send_coord(20'hABCDE, 20'h13579);
   endtask

   task automatic test_count_limit();
      set_config(16'hFFFF, 4'd8);
      send_coord(20'hFFFFF, 20'hFFFFF);
      send_coord(20'd0, 20'd0);
      set_config(16'hFFFF, 4'd15);       // clamped to the octave limit
      send_coord(20'd1, 20'hFFFFE);
      send_coord(20'h80000, 20'h7FFFF);
      set_config(16'd0, 4'd9);
      send_coord(20'h3C3C3, 20'hC3C3C);
      set_config(16'd1, 4'd2);
      send_coord(20'hFFFFF, 20'hFFFFF);
      send_coord(20'd0, 20'd0);
   endtask

   task automatic test_random(int phases, int per_phase);
      logic [3:0] octs;
      for (int p = 0; p < phases; p++) begin
         case ($urandom_range(0, 5))
            0:       octs = 4'($urandom_range(8, 15));
            1:       octs = 4'($urandom_range(0, 1));
            default: octs = 4'($urandom_range(2, 4));
         endcase
         set_config(16'($urandom), octs);
         for (int i = 0; i < per_phase; i++)
            send_coord(20'($urandom), 20'($urandom));
      end
   endtask

   task automatic test_backpressure();
      set_config(16'($urandom), 4'd2);
      hold_req = 1'b1;
      for (int i = 0; i < 6; i++) send_coord(20'($urandom), 20'($urandom));
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cur_pers    = 16'd8192;
      cur_octaves = 4'd4;
      mismatches  = 0;
      quiet       = 1'b0;
      hold_req    = 1'b0;
      stall_cnt   = 0;
      hold_cnt    = 0;
      idle_cycles = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults();
      test_few_octaves();
      test_count_limit();
      test_backpressure();
      test_random(40, 22);
      quiet = 1'b1;
      test_random(4, 25);

      wait_idle();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && noise_queue.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/vnos_pkg.sv
hw/rtl/vnos_div.sv
hw/rtl/vnos_hash.sv
hw/rtl/vnos_datapath.sv
hw/rtl/vnos_ctrl.sv
hw/rtl/value_noise_octave_sum.sv
hw/rtl/vnos_checker.sv
tb/tb_top.sv
